// File: sv/sorted_table_binary_search_defines.svh
// assertion macros shared by the checker of the sorted table search block
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define STBS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is held
`define STBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/stbs_pkg.sv
// package: sizes, command codes, state type and helpers of the table search block
`timescale 1ns / 1ps
`default_nettype none
package stbs_pkg;

  localparam int DEPTH     = 1024;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_t;

  // probe point lo + (hi - lo) / 2 with hi = end - 1, only called with lo < end
  function automatic logic [ADDR_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                               input logic [CNT_W-1:0] last);
    logic [CNT_W-1:0] span;
    logic [CNT_W-1:0] mid;
    span = last - lo - CNT_W'(1);
    mid  = lo + (span >> 1);
    return mid[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/sorted_table_binary_search.sv
// a load is written straight from idle and gives no result; a search goes from idle to
// probe, then to compare for each of its probes (at most 11), then to done, where it waits
// for the output register; one probe a cycle, bound by the single read port of the table ram
// a search holds off the input until its result sits in the output register
// reset: synchronous active-low rst_n clears control state and entry_count;
// table contents are undefined until written, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module sorted_table_binary_search
  import stbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: entry_count
  input  wire logic        cfg_wr_en,
  input  wire logic [10:0] cfg_wr_data,
  // input stream
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [47:0] in_tdata,   // [9:0] slot, [41:10] value, [47:42] zero
  input  wire logic [0:0]  in_tuser,   // [0] command
  // result stream
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [15:0] out_tdata,  // [9:0] position, [15:10] zero
  output      logic [0:0]  out_tuser   // [0] found
);

  // configuration register, saturated to the table depth when a search starts
  logic [CNT_W-1:0] entry_count_r;

  // search state
  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      lo_r, lo_nxt;
  logic [CNT_W-1:0]      end_r, end_nxt;     // exclusive upper bound, hi + 1
  logic [ADDR_W-1:0]     mid_r, mid_nxt;
  logic [WORD_BITS-1:0]  key_r, key_nxt;
  logic                  res_found_r, res_found_nxt;
  logic [ADDR_W-1:0]     res_pos_r, res_pos_nxt;

  // output register
  logic                  out_valid_r;
  logic                  out_found_r;
  logic [ADDR_W-1:0]     out_pos_r;
  logic                  out_load;

  // ram ports
  logic                  wr_en;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [WORD_BITS-1:0]  rd_data;

  // unpacked input fields
  logic                  in_cmd;
  logic [ADDR_W-1:0]     in_slot;
  logic [WORD_BITS-1:0]  in_value;
  logic                  in_xfer;
  logic [CNT_W-1:0]      n_eff;

  // candidate bounds after a compare
  logic [CNT_W-1:0]      cand_lo;
  logic [CNT_W-1:0]      cand_end;
  logic                  hit;
  logic                  key_above;

  assign in_cmd   = in_tuser[0];
  assign in_slot  = in_tdata[ADDR_W-1:0];
  assign in_value = in_tdata[ADDR_W +: WORD_BITS];

  // loads are written only from idle and reads happen only outside idle,
  // so the single-port pattern needs no forwarding
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  assign n_eff = (entry_count_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : entry_count_r;

  // compare the word read at mid against the key, then narrow the range
  assign hit       = (rd_data == key_r);
  assign key_above = ($signed(rd_data) < $signed(key_r));

  always_comb begin
    if (key_above) begin
      cand_lo  = {1'b0, mid_r} + CNT_W'(1);
      cand_end = end_r;
    end else begin
      cand_lo  = lo_r;
      cand_end = {1'b0, mid_r};
    end
  end

  stbs_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (WORD_BITS),
    .ADDR_P  (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_slot),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_wr_en) begin
      entry_count_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers of the search, no reset needed
  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    end_r       <= end_nxt;
    mid_r       <= mid_nxt;
    key_r       <= key_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    end_nxt       = end_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = mid_r;
    out_load      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_cmd == CMD_LOAD) begin
            wr_en = 1'b1;
          end else begin
            key_nxt   = in_value;
            lo_nxt    = '0;
            end_nxt   = n_eff;
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        // first probe, or straight to not found for an empty table
        if (lo_r < end_r) begin
          mid_nxt   = mid_of(lo_r, end_r);
          rd_en     = 1'b1;
          rd_addr   = mid_nxt;
          state_nxt = S_CMP;
        end else begin
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          state_nxt     = S_DONE;
        end
      end
      S_CMP: begin
        if (hit) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = mid_r;
          state_nxt     = S_DONE;
        end else begin
          lo_nxt  = cand_lo;
          end_nxt = cand_end;
          if (cand_lo < cand_end) begin
            // issue the next probe in the same cycle as the compare
            mid_nxt = mid_of(cand_lo, cand_end);
            rd_en   = 1'b1;
            rd_addr = mid_nxt;
          end else begin
            res_found_nxt = 1'b0;
            res_pos_nxt   = '0;
            state_nxt     = S_DONE;
          end
        end
      end
      S_DONE: begin
        // hand over once the output register is free or being drained
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= res_found_r;
      out_pos_r   <= res_pos_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {{(16 - ADDR_W){1'b0}}, out_pos_r};

endmodule
`default_nettype wire

// File: sv/stbs_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module stbs_ram #(
  parameter int DEPTH_P = 1024,
  parameter int WIDTH_P = 32,
  parameter int ADDR_P  = $clog2(DEPTH_P)
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [ADDR_P-1:0]  wr_addr,
  input  wire logic [WIDTH_P-1:0] wr_data,
  input  wire logic               rd_en,
  input  wire logic [ADDR_P-1:0]  rd_addr,
  output      logic [WIDTH_P-1:0] rd_data
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: sv/stbs_checker.sv
// port-level checker of the table search block and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_table_binary_search_defines.svh"
module stbs_checker
  import stbs_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [0:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  // a stalled result keeps its payload
  `STBS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // a miss reports position zero
  `STBS_ASSERT_SAME(a_miss_zero, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata == 16'd0, "not found with non-zero position")

  // a load never produces a result
  `STBS_ASSERT_NEXT(a_load_silent, clk, rst_n, in_tvalid && in_tready && (in_tuser[0] == CMD_LOAD) && !out_tvalid, !out_tvalid, "result after a load")

  // a search holds off the input while it runs
  `STBS_ASSERT_NEXT(a_search_busy, clk, rst_n, in_tvalid && in_tready && (in_tuser[0] == CMD_SEARCH), !in_tready, "input taken during a search")

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// File: sim/tb_sorted_table_binary_search.sv
// testbench for the sorted table search block, checked against a shadow copy of the table
`timescale 1ns / 1ps
module tb_sorted_table_binary_search;
  import stbs_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int SETTLE      = 20;     // cycles allowed for a trailing load to finish
  localparam int ITEM_TARGET = 1900;
  localparam int MAX_SHOWN   = 200;

  typedef struct packed {
    logic                 cmd;
    logic [ADDR_W-1:0]    slot;
    logic [WORD_BITS-1:0] value;
  } table_op_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] at;
  } lookup_t;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;
  logic             in_tvalid   = 1'b0;
  logic             in_tready;
  logic [47:0]      in_tdata    = '0;   // [9:0] slot, [41:10] value, [47:42] zero
  logic [0:0]       in_tuser    = '0;   // [0] command
  logic             out_tvalid;
  logic             out_tready  = 1'b0;
  logic [15:0]      out_tdata;          // [9:0] position, [15:10] zero
  logic [0:0]       out_tuser;          // [0] found

  sorted_table_binary_search dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow of the table as the block sees it, updated on each accepted load
  logic [WORD_BITS-1:0] table_image [DEPTH];
  logic [CNT_W-1:0]     live_count = '0;

  // the table as it will stand once everything queued so far has been sent
  logic [WORD_BITS-1:0] staged_table [DEPTH];
  bit                   staged_ok [DEPTH];
  int                   staged_count = 0;

  // ascending layout of the current phase: base + (slot >> shift) * step
  logic [WORD_BITS-1:0] lay_base     = '0;
  logic [WORD_BITS-1:0] lay_step     = '0;
  int                   lay_shift    = 0;
  bit                   lay_scramble = 1'b0;

  table_op_t ops_to_send[$];
  lookup_t   lookups_due[$];
  table_op_t on_bus;
  int        ops_queued = 0;
  int        mismatches = 0;
  int        cycles     = 0;
  int        idle_run[2] = '{0, 0};
  int        calm_run[2] = '{0, 0};

  function automatic int span_of(input logic [CNT_W-1:0] count);
    return (count > DEPTH) ? DEPTH : int'(count);
  endfunction

  // binary search over slots 0 to span-1 of either table copy; on the staged copy it
  // stops at the first probe of a slot not yet loaded in this phase and returns it
  function automatic lookup_t locate_key(input logic [WORD_BITS-1:0] key, input int span,
                                         input bit staged, output int unloaded);
    int                   lo;
    int                   hi;
    int                   mid;
    logic [WORD_BITS-1:0] probe;
    lookup_t              res;
    res      = '0;
    unloaded = -1;
    lo       = 0;
    hi       = span - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (staged && !staged_ok[mid]) begin
        unloaded = mid;
        return res;
      end
      probe = staged ? staged_table[mid] : table_image[mid];
      if (probe == key) begin
        res.hit = 1'b1;
        res.at  = ADDR_W'(mid);
        return res;
      end
      if ($signed(probe) < $signed(key)) lo = mid + 1;
      else hi = mid - 1;
    end
    return res;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones, now and then a calm stretch
  function automatic int idle_len(input int side);
    int r;
    if (calm_run[side] > 0) begin
      calm_run[side]--;
      return 0;
    end
    r = $urandom_range(99, 0);
    if (r < 2) begin
      calm_run[side] = $urandom_range(80, 20);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [WORD_BITS-1:0] layout_word(input int s);
    if (lay_scramble) return $urandom;
    return lay_base + WORD_BITS'(s >> lay_shift) * lay_step;
  endfunction

  task automatic report(input string what);
    if (mismatches < MAX_SHOWN) $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  task automatic stage_load(input logic [ADDR_W-1:0] slot, input logic [WORD_BITS-1:0] word);
    table_op_t op;
    op.cmd             = CMD_LOAD;
    op.slot            = slot;
    op.value           = word;
    staged_table[slot] = word;
    staged_ok[slot]    = 1'b1;
    ops_to_send        = {ops_to_send, op};
    ops_queued++;
  endtask

  // loads every slot the search would probe that is not yet known, then the search itself
  task automatic stage_search(input logic [WORD_BITS-1:0] key, input logic [ADDR_W-1:0] junk);
    table_op_t op;
    int        gap;
    void'(locate_key(key, staged_count, 1'b1, gap));
    while (gap >= 0) begin
      stage_load(ADDR_W'(gap), layout_word(gap));
      void'(locate_key(key, staged_count, 1'b1, gap));
    end
    op.cmd      = CMD_SEARCH;
    op.slot     = junk;
    op.value    = key;
    ops_to_send = {ops_to_send, op};
    ops_queued++;
  endtask

  // sampled at the falling edge so that all transfers of the cycle have settled
  task automatic wait_drained();
    @(negedge clk);
    while (ops_to_send.size() != 0 || in_tvalid || lookups_due.size() != 0) @(negedge clk);
  endtask

  // sender holds off until every search result is back, then the register is written
  task automatic set_entry_count(input logic [CNT_W-1:0] count);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    live_count   = count;
    @(negedge clk);
    staged_count = span_of(count);
  endtask

  // input side: presents queued operations and tracks each accepted transfer
  always @(posedge clk) begin
    int spare;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (on_bus.cmd == CMD_LOAD) table_image[on_bus.slot] = on_bus.value;
        else lookups_due = {lookups_due,
                            locate_key(on_bus.value, span_of(live_count), 1'b0, spare)};
        idle_run[0] = idle_len(0);
      end
      if (!in_tvalid || in_tready) begin
        if (idle_run[0] > 0) begin
          idle_run[0]--;
          in_tvalid <= 1'b0;
        end else if (ops_to_send.size() != 0) begin
          on_bus     = ops_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {6'b0, on_bus.value, on_bus.slot};
          in_tuser  <= on_bus.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side: random back-pressure, each result matched against the oldest search
  always @(posedge clk) begin
    lookup_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (lookups_due.size() == 0) begin
          report("result transfer with no search outstanding");
        end else begin
          want = lookups_due.pop_front();
          if (out_tuser[0] !== want.hit)
            report($sformatf("found %b, expected %b", out_tuser[0], want.hit));
          if (out_tdata[ADDR_W-1:0] !== want.at)
            report($sformatf("position %0d, expected %0d", out_tdata[ADDR_W-1:0], want.at));
        end
        idle_run[1] = idle_len(1);
      end
      if (idle_run[1] > 0) begin
        idle_run[1]--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int                   phase;
    int                   stop;
    int                   r;
    int                   s;
    int                   i;
    logic [CNT_W-1:0]     count;
    logic [WORD_BITS-1:0] key;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table straight after reset: not found without any probe
    stage_search(32'h0000_0000, '0);
    // word extremes in ascending order, plus the top slot and slot 0x2AA
    stage_load(10'd0, 32'h8000_0000);
    stage_load(10'd1, 32'hFFFF_FFFF);
    stage_load(10'd2, 32'h0000_0000);
    stage_load(10'd3, 32'h7FFF_FFFF);
    stage_load(10'd1023, 32'h5555_5555);
    stage_load(10'h2AA, 32'hAAAA_AAAA);
    set_entry_count(11'd4);
    stage_search(32'h8000_0000, '0);
    stage_search(32'hFFFF_FFFF, '0);
    stage_search(32'h0000_0000, '0);
    stage_search(32'h7FFF_FFFF, '0);
    stage_search(32'h0000_0001, '0);
    stage_search(32'h8000_0001, 10'd1023);   // slot field ignored on a search
    set_entry_count(11'd1);
    stage_search(32'h8000_0000, '0);
    stage_search(32'h7FFF_FFFF, '0);

    phase = 0;
    while (ops_queued < ITEM_TARGET) begin
      case (phase)
        0: count = 11'd1024;
        1: count = 11'd2047;   // beyond the depth, taken as full depth
        2: count = 11'd1023;
        3: count = 11'd0;
        4: count = 11'd1;
        5: count = 11'd2;
        6: count = 11'd3;
        default: begin
          r = $urandom_range(99, 0);
          if (r < 50) count = CNT_W'($urandom_range(40, 4));
          else if (r < 80) count = CNT_W'($urandom_range(1024, 41));
          else count = CNT_W'($urandom_range(2047, 1025));
        end
      endcase
      set_entry_count(count);

      // fresh layout: any slot probed in this phase is reloaded from it first
      for (i = 0; i < DEPTH; i++) staged_ok[i] = 1'b0;
      lay_scramble = ($urandom_range(99, 0) < 15);   // unsorted phase
      lay_shift    = $urandom_range(1, 0);           // shift of one gives pairs of equal words
      case ($urandom_range(5, 0))
        0:       lay_step = 32'd0;
        1:       lay_step = 32'd1;
        2:       lay_step = $urandom_range(16, 2);
        3:       lay_step = $urandom_range(100000, 17);
        4:       lay_step = 32'd2_000_000;
        default: lay_step = 32'd4_000_000;
      endcase
      lay_base = 32'h8000_0000 + $urandom_range(32'hFFFF_FFFF - 32'd1023 * lay_step, 0);
      if ($urandom_range(9, 0) == 0) lay_base = 32'h8000_0000;

      stop = ops_queued + $urandom_range(150, 90);
      while (ops_queued < stop) begin
        r   = $urandom_range(99, 0);
        s   = (staged_count > 0) ? $urandom_range(staged_count - 1, 0) : 0;
        key = staged_ok[s] ? staged_table[s] : layout_word(s);
        if (r < 60) stage_search(key, ADDR_W'($urandom));
        else if (r < 75) stage_search((r % 2) ? key + 32'd1 : key - 32'd1, ADDR_W'($urandom));
        else if (r < 83) stage_load(ADDR_W'($urandom), $urandom);   // may break the order
        else if (r < 85) stage_search(32'h8000_0000, '0);
        else if (r < 87) stage_search(32'h7FFF_FFFF, '0);
        else stage_search($urandom, ADDR_W'($urandom));
      end
      phase++;
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && lookups_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
